[hdl/pbsd_pkg.sv]
// Shared types and codes for the bytecode stream decoder.
package pbsd_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EOF      = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_PREFIX   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [7:0] CFG_THRESHOLD = 8'd0;
    localparam logic [7:0] CFG_PREFIX    = 8'd1;
    localparam logic [7:0] CFG_MASK0     = 8'd2;
    localparam logic [7:0] CFG_MASK1     = 8'd3;
    localparam logic [7:0] CFG_MASK2     = 8'd4;
    localparam logic [7:0] CFG_MASK3     = 8'd5;

    localparam logic [7:0] THRESHOLD_RESET = 8'd90;
    localparam logic [7:0] PREFIX_RESET    = 8'd145;
    localparam logic [7:0] COUNT_MAX       = 8'hFF;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_END  = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] code_byte;
    } pbsd_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] start_offset;
        logic [31:0] following_offset;
        logic [31:0] byte_length;
        logic [7:0]  prefix_count;
        logic [63:0] argument_value;
        logic [7:0]  opcode_value;
        logic        is_defined;
        logic        carries_argument;
    } pbsd_out_t;

    typedef struct packed {
        logic [7:0]   threshold;
        logic [7:0]   prefix_op;
        logic [255:0] defined;
    } pbsd_cfg_t;

endpackage

[hdl/pbsd_cfg.sv]
// Configuration register bank for the bytecode stream decoder.
module pbsd_cfg
    import pbsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output pbsd_cfg_t   cfg
);

    logic [7:0]  threshold_reg;
    logic [7:0]  prefix_reg;
    logic [63:0] mask0_reg;
    logic [63:0] mask1_reg;
    logic [63:0] mask2_reg;
    logic [63:0] mask3_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            prefix_reg    <= PREFIX_RESET;
            mask0_reg     <= '0;
            mask1_reg     <= '0;
            mask2_reg     <= '0;
            mask3_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[7:0];
                CFG_PREFIX:    prefix_reg    <= cfg_data[7:0];
                CFG_MASK0:     mask0_reg     <= cfg_data;
                CFG_MASK1:     mask1_reg     <= cfg_data;
                CFG_MASK2:     mask2_reg     <= cfg_data;
                CFG_MASK3:     mask3_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.threshold = threshold_reg;
    assign cfg.prefix_op = prefix_reg;
    assign cfg.defined   = {mask3_reg, mask2_reg, mask1_reg, mask0_reg};

endmodule

[hdl/pbsd_core.sv]
// Decode state and per-byte next-state and result logic.
module pbsd_core
    import pbsd_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      accept,
    input  pbsd_in_t  item,
    input  pbsd_cfg_t cfg,
    output logic      res_valid,
    output pbsd_out_t res
);

    localparam logic [1:0] PH_OPCODE = 2'd0;
    localparam logic [1:0] PH_LOW    = 2'd1;
    localparam logic [1:0] PH_HIGH   = 2'd2;
    localparam logic [1:0] PH_ERROR  = 2'd3;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [1:0]             phase_reg, phase_next;
    logic [7:0]             held_reg, held_next;
    logic [7:0]             low_reg, low_next;
    logic [63:0]            acc_reg, acc_next;
    logic [7:0]             count_reg, count_next;

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] len;
    logic [63:0]            start_wide;
    logic [63:0]            follow_wide;
    logic [63:0]            len_wide;
    logic [63:0]            acc_word;
    logic [7:0]             op;
    logic                   has_arg;
    logic                   emit;

    assign pos_inc     = pos_reg + OFFSET_BITS'(1);
    assign len         = pos_inc - start_reg;
    assign start_wide  = 64'(start_reg);
    assign follow_wide = 64'(pos_inc);
    assign len_wide    = 64'(len);
    assign acc_word    = {acc_reg[47:0], item.code_byte, low_reg};

    always_comb begin
        pos_next   = pos_reg;
        start_next = start_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        low_next   = low_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res        = '0;
        emit       = 1'b0;
        has_arg    = 1'b0;
        op         = item.code_byte;

        if (accept) begin
            if (item.command == CMD_END) begin
                if (phase_reg != PH_ERROR) begin
                    res_valid  = 1'b1;
                    res.status = (phase_reg == PH_OPCODE && count_reg == '0) ? ST_EOF
                                                                              : ST_TRUNC;
                end
                pos_next   = '0;
                start_next = '0;
                phase_next = PH_OPCODE;
                held_next  = '0;
                low_next   = '0;
                acc_next   = '0;
                count_next = '0;
            end else begin
                unique case (phase_reg)
                    PH_OPCODE: begin
                        pos_next = pos_inc;
                        if (item.code_byte < cfg.threshold) begin
                            if (count_reg != '0) begin
                                res_valid  = 1'b1;
                                res.status = ST_PREFIX;
                                phase_next = PH_ERROR;
                            end else begin
                                emit = 1'b1;
                            end
                        end else begin
                            held_next  = item.code_byte;
                            phase_next = PH_LOW;
                        end
                    end
                    PH_LOW: begin
                        pos_next   = pos_inc;
                        low_next   = item.code_byte;
                        phase_next = PH_HIGH;
                    end
                    PH_HIGH: begin
                        pos_next = pos_inc;
                        if (acc_reg[63:48] != '0) begin
                            res_valid  = 1'b1;
                            res.status = ST_OVERFLOW;
                            phase_next = PH_ERROR;
                        end else if (held_reg == cfg.prefix_op) begin
                            acc_next   = acc_word;
                            phase_next = PH_OPCODE;
                            if (count_reg != COUNT_MAX) begin
                                count_next = count_reg + 8'd1;
                            end
                        end else begin
                            emit    = 1'b1;
                            has_arg = 1'b1;
                            op      = held_reg;
                        end
                    end
                    PH_ERROR: begin
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (emit) begin
            res_valid            = 1'b1;
            res.status           = ST_OK;
            res.start_offset     = start_wide[31:0];
            res.following_offset = follow_wide[31:0];
            res.byte_length      = len_wide[31:0];
            res.prefix_count     = has_arg ? count_reg : 8'd0;
            res.argument_value   = has_arg ? acc_word : 64'd0;
            res.opcode_value     = op;
            res.is_defined       = cfg.defined[op];
            res.carries_argument = has_arg;
            start_next           = pos_inc;
            acc_next             = '0;
            count_next           = '0;
            phase_next           = PH_OPCODE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            start_reg <= '0;
            phase_reg <= PH_OPCODE;
            held_reg  <= '0;
            low_reg   <= '0;
            acc_reg   <= '0;
            count_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
            low_reg   <= low_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/pbsd_skid.sv]
// Result register with a skid stage between decoder and receiver.
module pbsd_skid
    import pbsd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  pbsd_out_t push_data,
    output logic      space,
    output logic      m_valid,
    input  logic      m_ready,
    output pbsd_out_t m_data
);

    logic      main_valid_reg;
    logic      skid_valid_reg;
    pbsd_out_t main_reg;
    pbsd_out_t skid_reg;
    logic      pop;

    assign pop     = main_valid_reg && m_ready;
    assign space   = !skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg && pop) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (push && (!main_valid_reg || m_ready)) begin
                main_valid_reg <= 1'b1;
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end else if (pop) begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg && pop) begin
            main_reg <= skid_reg;
        end else if (push && (!main_valid_reg || m_ready)) begin
            main_reg <= push_data;
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

endmodule

[hdl/python_bytecode_stream_decoder.sv]
// Top level of the streaming bytecode instruction decoder.
// Usage:
//   s_valid/s_ready/s_data carry one item per cycle while s_ready is high:
//   a code byte, or an end of code marker. m_valid/m_ready/m_data carry
//   decoded results: one per completed instruction, end of code, truncation
//   or error. cfg_valid/cfg_ready/cfg_index/cfg_data write configuration
//   registers; cfg_ready is always high. Write only while the decoder is idle.
// Timing:
//   One item per cycle sustained while s_ready is high. The decode is one
//   combinational pass from the state registers into the result register,
//   or into the skid register while the receiver stalls.
// Stall:
//   A skid register holds a second result while the receiver stalls;
//   s_ready drops only while the skid register is full.
// Reset:
//   Synchronous active-low aresetn clears decode state to offset zero,
//   empties the result stage and restores configuration defaults.
module python_bytecode_stream_decoder
    import pbsd_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pbsd_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pbsd_out_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    pbsd_cfg_t cfg;
    pbsd_out_t res;
    logic      res_valid;
    logic      accept;

    assign accept = s_valid && s_ready;

    pbsd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbsd_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .item      (s_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    pbsd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .space     (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[hdl/pbsd_checker.sv]
// Port-level assertions for the bytecode stream decoder, bound to the top level.
module pbsd_checker
    import pbsd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input pbsd_out_t m_data
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK || m_data.status == ST_EOF ||
                     m_data.status == ST_TRUNC || m_data.status == ST_PREFIX ||
                     m_data.status == ST_OVERFLOW))
        else $error("result status out of range");

    a_event_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |->
            (m_data.start_offset == '0 && m_data.following_offset == '0 &&
             m_data.byte_length == '0 && m_data.prefix_count == '0 &&
             m_data.argument_value == '0 && m_data.opcode_value == '0 &&
             !m_data.is_defined && !m_data.carries_argument))
        else $error("event result carries nonzero fields");

    a_no_arg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_OK && !m_data.carries_argument) |->
            (m_data.prefix_count == '0 && m_data.argument_value == '0))
        else $error("argumentless instruction reports an argument");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind python_bytecode_stream_decoder pbsd_checker u_pbsd_checker (.*);
